[rtl/lq_pkg.sv]
// ----------------------------------------------------------------------------
// lq_pkg
// Shared widths, codes and memory command types of the linked queue manager.
// ----------------------------------------------------------------------------
package lq_pkg;

   localparam int NUM_ENTRIES = 32;
   localparam int NUM_QUEUES  = 8;

   localparam int KIND_W   = 3;
   localparam int QUEUE_W  = 3;
   localparam int ENTRY_W  = 5;
   localparam int STATUS_W = 2;
   localparam int TAG_W    = 4;
   localparam int COUNT_W  = 6;

   // owner tag codes beyond the queue numbers
   localparam logic [TAG_W-1:0] TAG_FREE  = TAG_W'(NUM_QUEUES);
   localparam logic [TAG_W-1:0] TAG_LOOSE = TAG_W'(NUM_QUEUES + 1);

   localparam logic [QUEUE_W:0]   QUEUE_LIMIT = (QUEUE_W+1)'(NUM_QUEUES);
   localparam logic [ENTRY_W:0]   ENTRY_LIMIT = (ENTRY_W+1)'(NUM_ENTRIES);
   localparam logic [COUNT_W-1:0] POOL_SIZE   = COUNT_W'(NUM_ENTRIES);

   localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FREE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OUT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_HEAD   = 3'd5;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_BAD       = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_LINK,
      S_UNLINK,
      S_CLEAR,
      S_DONE
   } lq_state_type;

   typedef struct packed {
      logic               rd_en;
      logic [ENTRY_W-1:0] rd_addr_a;
      logic [ENTRY_W-1:0] rd_addr_b;
      logic               nl_we;
      logic [ENTRY_W-1:0] nl_waddr;
      logic [ENTRY_W-1:0] nl_wdata;
      logic               pl_we;
      logic [ENTRY_W-1:0] pl_waddr;
      logic [ENTRY_W-1:0] pl_wdata;
      logic               tg_we;
      logic [ENTRY_W-1:0] tg_waddr;
      logic [TAG_W-1:0]   tg_wdata;
   } lq_mem_cmd_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] nl_a;
      logic [ENTRY_W-1:0] nl_b;
      logic [ENTRY_W-1:0] pl_a;
      logic [TAG_W-1:0]   tg_a;
   } lq_mem_rdata_type;

endpackage

[rtl/lq_if.sv]
// ----------------------------------------------------------------------------
// lq_if
// Request and response channels of the linked queue manager.
// ----------------------------------------------------------------------------
interface lq_req_if;
   import lq_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [QUEUE_W-1:0] queue_id;
   logic [ENTRY_W-1:0] entry;

   modport source (output valid, kind, queue_id, entry, input ready);
   modport sink   (input valid, kind, queue_id, entry, output ready);
endinterface

interface lq_rsp_if;
   import lq_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  result_entry;

   modport source (output valid, status, result_entry, input ready);
   modport sink   (input valid, status, result_entry, output ready);
endinterface

[rtl/lq_link_mem.sv]
// ----------------------------------------------------------------------------
// lq_link_mem
// Next link, previous link and owner tag memories, read through registers,
// with per-entry written bits standing in for the reset contents.
// ----------------------------------------------------------------------------
module lq_link_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  lq_pkg::lq_mem_cmd_type   mem_cmd,
   output lq_pkg::lq_mem_rdata_type mem_rd
);
   import lq_pkg::*;

   logic [ENTRY_W-1:0] nl_mem [NUM_ENTRIES];
   logic [ENTRY_W-1:0] pl_mem [NUM_ENTRIES];
   logic [TAG_W-1:0]   tg_mem [NUM_ENTRIES];

   logic [NUM_ENTRIES-1:0] nl_vld_ff;
   logic [NUM_ENTRIES-1:0] pl_vld_ff;
   logic [NUM_ENTRIES-1:0] tg_vld_ff;

   logic [ENTRY_W-1:0] addr_a_ff;
   logic [ENTRY_W-1:0] addr_b_ff;
   logic [ENTRY_W-1:0] nl_a_ff;
   logic [ENTRY_W-1:0] nl_b_ff;
   logic [ENTRY_W-1:0] pl_a_ff;
   logic [TAG_W-1:0]   tg_a_ff;
   logic               nl_a_vld_ff;
   logic               nl_b_vld_ff;
   logic               pl_a_vld_ff;
   logic               tg_a_vld_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.nl_we) begin
         nl_mem[mem_cmd.nl_waddr] <= mem_cmd.nl_wdata;
      end
      if (mem_cmd.pl_we) begin
         pl_mem[mem_cmd.pl_waddr] <= mem_cmd.pl_wdata;
      end
      if (mem_cmd.tg_we) begin
         tg_mem[mem_cmd.tg_waddr] <= mem_cmd.tg_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nl_vld_ff <= '0;
         pl_vld_ff <= '0;
         tg_vld_ff <= '0;
      end else begin
         if (mem_cmd.nl_we) begin
            nl_vld_ff[mem_cmd.nl_waddr] <= 1'b1;
         end
         if (mem_cmd.pl_we) begin
            pl_vld_ff[mem_cmd.pl_waddr] <= 1'b1;
         end
         if (mem_cmd.tg_we) begin
            tg_vld_ff[mem_cmd.tg_waddr] <= 1'b1;
         end
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         addr_a_ff   <= mem_cmd.rd_addr_a;
         addr_b_ff   <= mem_cmd.rd_addr_b;
         nl_a_ff     <= nl_mem[mem_cmd.rd_addr_a];
         nl_b_ff     <= nl_mem[mem_cmd.rd_addr_b];
         pl_a_ff     <= pl_mem[mem_cmd.rd_addr_a];
         tg_a_ff     <= tg_mem[mem_cmd.rd_addr_a];
         nl_a_vld_ff <= nl_vld_ff[mem_cmd.rd_addr_a];
         nl_b_vld_ff <= nl_vld_ff[mem_cmd.rd_addr_b];
         pl_a_vld_ff <= pl_vld_ff[mem_cmd.rd_addr_a];
         tg_a_vld_ff <= tg_vld_ff[mem_cmd.rd_addr_a];
      end
   end

   // unwritten entries: free stack links each entry to the one below
   always_comb begin
      mem_rd.nl_a = nl_a_vld_ff ? nl_a_ff :
                    ((addr_a_ff == '0) ? '0 : addr_a_ff - ENTRY_W'(1));
      mem_rd.nl_b = nl_b_vld_ff ? nl_b_ff :
                    ((addr_b_ff == '0) ? '0 : addr_b_ff - ENTRY_W'(1));
      mem_rd.pl_a = pl_a_vld_ff ? pl_a_ff : '0;
      mem_rd.tg_a = tg_a_vld_ff ? tg_a_ff : TAG_FREE;
   end

endmodule

[rtl/lq_ctrl.sv]
// ----------------------------------------------------------------------------
// lq_ctrl
// Request sequencer: queue tails, free stack top, link updates and the
// response register.
// ----------------------------------------------------------------------------
module lq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   lq_req_if.sink                   req_bus,
   lq_rsp_if.source                 rsp_bus,
   output lq_pkg::lq_mem_cmd_type   mem_cmd,
   input  lq_pkg::lq_mem_rdata_type mem_rd
);
   import lq_pkg::*;

   lq_state_type state_ff, state_in;

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [QUEUE_W-1:0] q_ff, q_in;
   logic [ENTRY_W-1:0] e_ff, e_in;
   logic [ENTRY_W-1:0] x_ff, x_in;

   logic [ENTRY_W-1:0]    tail_ff [NUM_QUEUES];
   logic [ENTRY_W-1:0]    tail_in [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] nonempty_ff, nonempty_in;
   logic [ENTRY_W-1:0]    free_top_ff, free_top_in;
   logic [COUNT_W-1:0]    free_count_ff, free_count_in;

   status_type         pend_status_ff, pend_status_in;
   logic [ENTRY_W-1:0] pend_entry_ff, pend_entry_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_entry_ff, rsp_entry_in;

   logic               q_ok;
   logic               e_ok;
   logic               q_nonempty;
   logic [ENTRY_W-1:0] q_tail;
   logic               slot_free;
   logic               fin;
   status_type         fin_status;
   logic [ENTRY_W-1:0] fin_entry;

   assign q_ok       = {1'b0, q_ff} < QUEUE_LIMIT;
   assign e_ok       = {1'b0, e_ff} < ENTRY_LIMIT;
   assign q_nonempty = nonempty_ff[q_ff];
   assign q_tail     = tail_ff[q_ff];
   assign slot_free  = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.result_entry = rsp_entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         nonempty_ff   <= '0;
         free_top_ff   <= ENTRY_W'(NUM_ENTRIES - 1);
         free_count_ff <= POOL_SIZE;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         nonempty_ff   <= nonempty_in;
         free_top_ff   <= free_top_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         tail_ff       <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      q_ff           <= q_in;
      e_ff           <= e_in;
      x_ff           <= x_in;
      pend_status_ff <= pend_status_in;
      pend_entry_ff  <= pend_entry_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entry_ff   <= rsp_entry_in;
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      q_in           = q_ff;
      e_in           = e_ff;
      x_in           = x_ff;
      tail_in        = tail_ff;
      nonempty_in    = nonempty_ff;
      free_top_in    = free_top_ff;
      free_count_in  = free_count_ff;
      pend_status_in = pend_status_ff;
      pend_entry_in  = pend_entry_ff;
      rsp_valid_in   = rsp_bus.ready ? 1'b0 : rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entry_in   = rsp_entry_ff;
      mem_cmd        = '0;
      fin            = 1'b0;
      fin_status     = ST_BAD;
      fin_entry      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               kind_in           = req_bus.kind;
               q_in              = req_bus.queue_id;
               e_in              = req_bus.entry;
               mem_cmd.rd_en     = 1'b1;
               mem_cmd.rd_addr_a = req_bus.entry;
               mem_cmd.rd_addr_b = (req_bus.kind == KIND_ALLOC) ? free_top_ff :
                                   tail_ff[req_bus.queue_id];
               state_in          = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (kind_ff)
               KIND_ALLOC: begin
                  fin = 1'b1;
                  if (free_count_ff == '0) begin
                     fin_status = ST_EMPTY;
                  end else begin
                     free_top_in      = mem_rd.nl_b;
                     free_count_in    = free_count_ff - COUNT_W'(1);
                     mem_cmd.nl_we    = 1'b1;
                     mem_cmd.nl_waddr = free_top_ff;
                     mem_cmd.nl_wdata = '0;
                     mem_cmd.pl_we    = 1'b1;
                     mem_cmd.pl_waddr = free_top_ff;
                     mem_cmd.pl_wdata = '0;
                     mem_cmd.tg_we    = 1'b1;
                     mem_cmd.tg_waddr = free_top_ff;
                     mem_cmd.tg_wdata = TAG_LOOSE;
                     fin_status       = ST_OK;
                     fin_entry        = free_top_ff;
                  end
               end
               KIND_FREE: begin
                  fin = 1'b1;
                  if (e_ok && mem_rd.tg_a == TAG_LOOSE) begin
                     mem_cmd.nl_we    = 1'b1;
                     mem_cmd.nl_waddr = e_ff;
                     mem_cmd.nl_wdata = (free_count_ff == '0) ? '0 : free_top_ff;
                     mem_cmd.pl_we    = 1'b1;
                     mem_cmd.pl_waddr = e_ff;
                     mem_cmd.pl_wdata = '0;
                     mem_cmd.tg_we    = 1'b1;
                     mem_cmd.tg_waddr = e_ff;
                     mem_cmd.tg_wdata = TAG_FREE;
                     free_top_in      = e_ff;
                     free_count_in    = free_count_ff + COUNT_W'(1);
                     fin_status       = ST_OK;
                  end
               end
               KIND_INSERT: begin
                  if (q_ok && e_ok && mem_rd.tg_a == TAG_LOOSE) begin
                     mem_cmd.nl_we    = 1'b1;
                     mem_cmd.nl_waddr = e_ff;
                     mem_cmd.pl_we    = 1'b1;
                     mem_cmd.pl_waddr = e_ff;
                     mem_cmd.tg_we    = 1'b1;
                     mem_cmd.tg_waddr = e_ff;
                     mem_cmd.tg_wdata = TAG_W'(q_ff);
                     if (!q_nonempty) begin
                        // lone entry links to itself
                        mem_cmd.nl_wdata  = e_ff;
                        mem_cmd.pl_wdata  = e_ff;
                        nonempty_in[q_ff] = 1'b1;
                        tail_in[q_ff]     = e_ff;
                        fin               = 1'b1;
                        fin_status        = ST_OK;
                     end else begin
                        mem_cmd.nl_wdata = mem_rd.nl_b;
                        mem_cmd.pl_wdata = q_tail;
                        state_in         = S_LINK;
                     end
                  end else begin
                     fin = 1'b1;
                  end
               end
               KIND_REMOVE: begin
                  if (!q_ok) begin
                     fin = 1'b1;
                  end else if (!q_nonempty) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                  end else begin
                     // head is the tail's successor, fetch its links
                     x_in              = mem_rd.nl_b;
                     mem_cmd.rd_en     = 1'b1;
                     mem_cmd.rd_addr_a = mem_rd.nl_b;
                     mem_cmd.rd_addr_b = mem_rd.nl_b;
                     state_in          = S_UNLINK;
                  end
               end
               KIND_OUT: begin
                  if (!(q_ok && e_ok)) begin
                     fin = 1'b1;
                  end else if (!q_nonempty) begin
                     fin        = 1'b1;
                     fin_status = ST_EMPTY;
                  end else if (mem_rd.tg_a != TAG_W'(q_ff)) begin
                     fin        = 1'b1;
                     fin_status = ST_NOT_FOUND;
                  end else begin
                     x_in     = e_ff;
                     state_in = S_UNLINK;
                  end
               end
               KIND_HEAD: begin
                  fin = 1'b1;
                  if (q_ok) begin
                     if (!q_nonempty) begin
                        fin_status = ST_EMPTY;
                     end else begin
                        fin_status = ST_OK;
                        fin_entry  = mem_rd.nl_b;
                     end
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         S_LINK: begin
            // old tail and old head now point at the new entry
            mem_cmd.nl_we    = 1'b1;
            mem_cmd.nl_waddr = q_tail;
            mem_cmd.nl_wdata = e_ff;
            mem_cmd.pl_we    = 1'b1;
            mem_cmd.pl_waddr = mem_rd.nl_b;
            mem_cmd.pl_wdata = e_ff;
            tail_in[q_ff]    = e_ff;
            fin              = 1'b1;
            fin_status       = ST_OK;
         end
         S_UNLINK: begin
            if (mem_rd.pl_a == x_ff) begin
               nonempty_in[q_ff] = 1'b0;
               tail_in[q_ff]     = '0;
            end else begin
               mem_cmd.nl_we    = 1'b1;
               mem_cmd.nl_waddr = mem_rd.pl_a;
               mem_cmd.nl_wdata = mem_rd.nl_a;
               mem_cmd.pl_we    = 1'b1;
               mem_cmd.pl_waddr = mem_rd.nl_a;
               mem_cmd.pl_wdata = mem_rd.pl_a;
               if (q_tail == x_ff) begin
                  tail_in[q_ff] = mem_rd.pl_a;
               end
            end
            mem_cmd.tg_we    = 1'b1;
            mem_cmd.tg_waddr = x_ff;
            mem_cmd.tg_wdata = TAG_LOOSE;
            state_in         = S_CLEAR;
         end
         S_CLEAR: begin
            mem_cmd.nl_we    = 1'b1;
            mem_cmd.nl_waddr = x_ff;
            mem_cmd.nl_wdata = '0;
            mem_cmd.pl_we    = 1'b1;
            mem_cmd.pl_waddr = x_ff;
            mem_cmd.pl_wdata = '0;
            fin              = 1'b1;
            fin_status       = ST_OK;
            fin_entry        = x_ff;
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_entry_in  = pend_entry_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hand the word to the response register, or park it
      if (fin) begin
         if (slot_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = fin_status;
            rsp_entry_in  = fin_entry;
            state_in      = S_IDLE;
         end else begin
            pend_status_in = fin_status;
            pend_entry_in  = fin_entry;
            state_in       = S_DONE;
         end
      end
   end

endmodule

[rtl/pooled_linked_queue_manager_unit.sv]
// Steps, accept to response: alloc, free, head, insert into an empty queue and any
// request answered other than ok finish in the execute step; insert into a
// non-empty queue adds the link step, a remove or out that unlinks an entry adds
// the unlink and clear steps. One request at a time: the next is taken once the last
// one's response word is in the response register, so a held response delays it.
// Reset: synchronous; the pool comes up all free, queues empty, no clearing pass.
// ----------------------------------------------------------------------------
// pooled_linked_queue_manager_unit
// Entry pool with a free stack and circular doubly linked FIFO queues.
// ----------------------------------------------------------------------------
module pooled_linked_queue_manager_unit (
   input  logic     clock,
   input  logic     reset,
   lq_req_if.sink   req_bus,
   lq_rsp_if.source rsp_bus
);
   import lq_pkg::*;

   lq_mem_cmd_type   mem_cmd;
   lq_mem_rdata_type mem_rd;

   lq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .mem_cmd (mem_cmd),
      .mem_rd  (mem_rd)
   );

   lq_link_mem u_link_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .mem_rd  (mem_rd)
   );

endmodule

[test/tb_pooled_linked_queue_manager_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pooled_linked_queue_manager_unit
// Drives alloc, free, insert, remove, out and head requests, mostly
// well-formed against the current pool state, with random gaps and stalls
// on both channels. A behavioural copy of the free stack and the linked
// queues predicts each response word, which is then checked in order.
// ----------------------------------------------------------------------------
import lq_pkg::*;

typedef struct {
   status_type         status;
   logic [ENTRY_W-1:0] entry;
} lq_reply_type;

class queue_pool_scoreboard;
   logic [ENTRY_W-1:0] next_link [NUM_ENTRIES];
   logic [ENTRY_W-1:0] prev_link [NUM_ENTRIES];
   logic [TAG_W-1:0]   owner     [NUM_ENTRIES];
   logic [ENTRY_W-1:0] tail      [NUM_QUEUES];
   bit                 occupied  [NUM_QUEUES];
   logic [ENTRY_W-1:0] free_top;
   int                 free_count;
   lq_reply_type       expected_replies [$];
   int                 mismatches;

   function new();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         next_link[i] = (i == 0) ? '0 : ENTRY_W'(i - 1);
         prev_link[i] = '0;
         owner[i]     = TAG_FREE;
      end
      for (int q = 0; q < NUM_QUEUES; q++) begin
         tail[q]     = '0;
         occupied[q] = 1'b0;
      end
      free_top   = ENTRY_W'(NUM_ENTRIES - 1);
      free_count = NUM_ENTRIES;
      mismatches = 0;
   endfunction

   // take e out of queue q and leave it loose
   function void detach(logic [QUEUE_W-1:0] q, logic [ENTRY_W-1:0] e);
      logic [ENTRY_W-1:0] prev_e, next_e;
      prev_e = prev_link[e];
      next_e = next_link[e];
      if (prev_e == e) begin
         occupied[q] = 1'b0;
         tail[q]     = '0;
      end else begin
         next_link[prev_e] = next_e;
         prev_link[next_e] = prev_e;
         if (tail[q] == e) tail[q] = prev_e;
      end
      next_link[e] = '0;
      prev_link[e] = '0;
      owner[e]     = TAG_LOOSE;
   endfunction

   function void note_request(logic [KIND_W-1:0] kind, logic [QUEUE_W-1:0] qid,
                              logic [ENTRY_W-1:0] ent);
      lq_reply_type       r;
      logic [ENTRY_W-1:0] t, h;
      bit                 q_ok, e_ok;
      r.status = ST_BAD;
      r.entry  = '0;
      q_ok = ({1'b0, qid} < QUEUE_LIMIT);
      e_ok = ({1'b0, ent} < ENTRY_LIMIT);
      case (kind)
         KIND_ALLOC: begin
            if (free_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               t            = free_top;
               free_top     = next_link[t];
               free_count--;
               next_link[t] = '0;
               prev_link[t] = '0;
               owner[t]     = TAG_LOOSE;
               r.status     = ST_OK;
               r.entry      = t;
            end
         end
         KIND_FREE: begin
            if (e_ok && owner[ent] == TAG_LOOSE) begin
               next_link[ent] = (free_count == 0) ? '0 : free_top;
               prev_link[ent] = '0;
               free_top       = ent;
               free_count++;
               owner[ent]     = TAG_FREE;
               r.status       = ST_OK;
            end
         end
         KIND_INSERT: begin
            if (q_ok && e_ok && owner[ent] == TAG_LOOSE) begin
               if (!occupied[qid]) begin
                  next_link[ent] = ent;
                  prev_link[ent] = ent;
                  occupied[qid]  = 1'b1;
               end else begin
                  t              = tail[qid];
                  h              = next_link[t];
                  next_link[ent] = h;
                  prev_link[ent] = t;
                  prev_link[h]   = ent;
                  next_link[t]   = ent;
               end
               tail[qid]  = ent;
               owner[ent] = TAG_W'(qid);
               r.status   = ST_OK;
            end
         end
         KIND_REMOVE: begin
            if (q_ok) begin
               if (!occupied[qid]) begin
                  r.status = ST_EMPTY;
               end else begin
                  h = next_link[tail[qid]];
                  detach(qid, h);
                  r.status = ST_OK;
                  r.entry  = h;
               end
            end
         end
         KIND_OUT: begin
            if (q_ok && e_ok) begin
               if (!occupied[qid]) begin
                  r.status = ST_EMPTY;
               end else if (owner[ent] != TAG_W'(qid)) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  detach(qid, ent);
                  r.status = ST_OK;
                  r.entry  = ent;
               end
            end
         end
         KIND_HEAD: begin
            if (q_ok) begin
               if (!occupied[qid]) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.status = ST_OK;
                  r.entry  = next_link[tail[qid]];
               end
            end
         end
         default: ;
      endcase
      expected_replies.push_back(r);
   endfunction

   function void check_response(logic [STATUS_W-1:0] status, logic [ENTRY_W-1:0] entry);
      lq_reply_type want;
      if (expected_replies.size() == 0) begin
         $display("%0t: unexpected response word, status %0d entry %0d",
                  $time, status, entry);
         mismatches++;
         return;
      end
      want = expected_replies.pop_front();
      if (status !== want.status) begin
         $display("%0t: status mismatch, expected %0d actual %0d",
                  $time, want.status, status);
         mismatches++;
      end
      if (entry !== want.entry) begin
         $display("%0t: result_entry mismatch, expected %0d actual %0d",
                  $time, want.entry, entry);
         mismatches++;
      end
   endfunction

   // random entry that is loose, or queued in any queue
   function bit find_entry(bit queued, output logic [ENTRY_W-1:0] ent);
      int start, idx;
      start = $urandom_range(0, NUM_ENTRIES - 1);
      ent   = ENTRY_W'(start);
      for (int k = 0; k < NUM_ENTRIES; k++) begin
         idx = (start + k) % NUM_ENTRIES;
         if (queued ? (owner[idx] < TAG_FREE) : (owner[idx] == TAG_LOOSE)) begin
            ent = ENTRY_W'(idx);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction
endclass

module tb_pooled_linked_queue_manager_unit;

   localparam int WORD_COUNT      = 450;
   localparam int QUIET_AFTER     = 400;
   localparam int PHASE_WORDS     = 50;
   localparam int HOLD_OFF_AT     = 150;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 3000;

   localparam logic [KIND_W-1:0] KIND_RSVD_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD_HI = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_STORM = 2;

   logic clock;
   logic reset;

   lq_req_if req_if ();
   lq_rsp_if rsp_if ();

   queue_pool_scoreboard sb = new();

   int words_sent   = 0;
   int idle_odds    = 2;
   int stall_cycles = 0;
   bit quiet        = 1'b0;

   // cumulative weights: alloc, insert, free, remove, out, head; rest is noise
   int cut [3][6] = '{'{30, 60, 68, 78, 86, 94},
                      '{ 8, 20, 40, 62, 82, 92},
                      '{70, 88, 90, 94, 96, 98}};

   pooled_linked_queue_manager_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_word(logic [KIND_W-1:0] kind, logic [QUEUE_W-1:0] qid,
                            logic [ENTRY_W-1:0] ent);
      req_if.valid    <= 1'b1;
      req_if.kind     <= kind;
      req_if.queue_id <= qid;
      req_if.entry    <= ent;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(kind, qid, ent);
      words_sent++;
      if (!quiet && idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      send_word(KIND_HEAD,    3'd0, 5'd0);
      send_word(KIND_REMOVE,  3'd7, 5'd0);
      send_word(KIND_OUT,     3'd3, 5'd5);
      send_word(KIND_RSVD_LO, 3'd0, 5'd0);
      send_word(KIND_RSVD_HI, 3'd7, 5'd31);
      // free and insert of entries still on the free stack
      send_word(KIND_FREE,    3'd0, 5'd31);
      send_word(KIND_INSERT,  3'd0, 5'd31);
      send_word(KIND_ALLOC,   3'd0, 5'd0);
      send_word(KIND_ALLOC,   3'd0, 5'd0);
      send_word(KIND_ALLOC,   3'd0, 5'd0);
      send_word(KIND_INSERT,  3'd7, 5'd31);
      send_word(KIND_INSERT,  3'd7, 5'd30);
      send_word(KIND_INSERT,  3'd2, 5'd31);
      send_word(KIND_FREE,    3'd0, 5'd31);
      send_word(KIND_HEAD,    3'd7, 5'd0);
      send_word(KIND_OUT,     3'd2, 5'd30);
      send_word(KIND_OUT,     3'd7, 5'd29);
      send_word(KIND_INSERT,  3'd0, 5'd29);
      send_word(KIND_OUT,     3'd7, 5'd29);
      send_word(KIND_OUT,     3'd7, 5'd30);
      send_word(KIND_REMOVE,  3'd7, 5'd0);
      send_word(KIND_FREE,    3'd0, 5'd31);
      send_word(KIND_FREE,    3'd0, 5'd30);
      send_word(KIND_REMOVE,  3'd0, 5'd0);
   endtask

   task automatic send_random(int mode);
      int                 pick;
      bit                 well_formed;
      logic [KIND_W-1:0]  kind;
      logic [QUEUE_W-1:0] qid;
      logic [ENTRY_W-1:0] ent, found;
      pick        = $urandom_range(0, 99);
      well_formed = $urandom_range(0, 99) < 85;
      qid         = QUEUE_W'($urandom);
      ent         = ENTRY_W'($urandom);
      if (pick < cut[mode][0])      kind = KIND_ALLOC;
      else if (pick < cut[mode][1]) kind = KIND_INSERT;
      else if (pick < cut[mode][2]) kind = KIND_FREE;
      else if (pick < cut[mode][3]) kind = KIND_REMOVE;
      else if (pick < cut[mode][4]) kind = KIND_OUT;
      else if (pick < cut[mode][5]) kind = KIND_HEAD;
      else if (pick % 2 == 0)       kind = KIND_W'($urandom_range(KIND_RSVD_LO, KIND_RSVD_HI));
      else                          kind = KIND_W'($urandom);
      case (kind) inside
         KIND_FREE: begin
            if (well_formed && sb.find_entry(1'b0, found)) ent = found;
         end
         KIND_INSERT: begin
            // keep a couple of queues long
            if (pick % 2 == 0) qid = QUEUE_W'($urandom_range(0, 1));
            if (well_formed && sb.find_entry(1'b0, found)) ent = found;
         end
         KIND_REMOVE, KIND_HEAD: begin
            if (well_formed && sb.find_entry(1'b1, found)) qid = QUEUE_W'(sb.owner[found]);
         end
         KIND_OUT: begin
            // a broken out still names a busy queue, so the tag check is hit
            if (sb.find_entry(1'b1, found)) begin
               qid = QUEUE_W'(sb.owner[found]);
               if (well_formed) ent = found;
            end
         end
         default: ;
      endcase
      send_word(kind, qid, ent);
   endtask

   initial begin
      int mode;
      mode            = MODE_FILL;
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.kind     <= KIND_ALLOC;
      req_if.queue_id <= '0;
      req_if.entry    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int n = 0; n < WORD_COUNT; n++) begin
         if (n % PHASE_WORDS == 0) begin
            mode      = (n / PHASE_WORDS) % 3;
            idle_odds = $urandom_range(0, 4);
         end
         if (n >= QUIET_AFTER) quiet = 1'b1;
         send_random(mode);
      end
      req_if.valid <= 1'b0;
      while (sb.expected_replies.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("pooled_linked_queue_manager_unit verification clean");
      end else begin
         $display("pooled_linked_queue_manager_unit verification failed");
      end
      $finish;
   end

   // response side: short random stalls and one long hold-off
   initial begin
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet && !held && words_sent >= HOLD_OFF_AT) begin
            held = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && idle_odds != 0 && $urandom_range(0, 4 * idle_odds) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready) begin
         sb.check_response(rsp_if.status, rsp_if.result_entry);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("pooled_linked_queue_manager_unit verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
